[rtl/ritoa_pkg.sv]
package ritoa_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int MAX_DIGITS_DEF = 32;

	localparam logic [5:0] RADIX_MIN  = 6'd2;
	localparam logic [5:0] RADIX_MAX  = 6'd36;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ALPHA = 8'h41;
	localparam logic [5:0] ALPHA_LO   = 6'd10;
	localparam logic [5:0] ALPHA_HI   = 6'd22;

	typedef struct packed {
		logic [VALUE_BITS-1:0] number_value;
		logic [5:0]            radix;
		logic [5:0]            fixed_width;
	} ritoa_in_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
		logic [5:0] text_length;
	} ritoa_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_LEN,
		ST_RD,
		ST_LOAD
	} ritoa_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic set_len;
		logic rd;
		logic emit;
	} ritoa_cmd_t;

	typedef struct packed {
		logic div_last;
		logic q_zero;
		logic store_full;
		logic pos_zero;
		logic out_free;
	} ritoa_sts_t;

	// digits ten to twenty-two are letters, the rest sit above '0'
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d >= ALPHA_LO && d <= ALPHA_HI) begin
			c = CHAR_ALPHA + {2'b00, d - ALPHA_LO};
		end else begin
			c = CHAR_ZERO + {2'b00, d};
		end
		return c;
	endfunction

endpackage

[rtl/ritoa_ram.sv]
module ritoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/ritoa_datapath.sv]
module ritoa_datapath import ritoa_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ritoa_in_t  num_word,
	input  ritoa_cmd_t cmd,
	output ritoa_sts_t sts,
	output logic       txt_valid,
	input  logic       txt_stall,
	output ritoa_out_t txt_word
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int BW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] quot_q;
	logic [5:0]            rem_q;
	logic [5:0]            base_q;
	logic [BW-1:0]         bit_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         width_q;
	logic [CW-1:0]         len_q;
	logic [AW-1:0]         pos_q;
	logic                  txt_valid_q;
	ritoa_out_t            txt_q;

	logic [6:0] shifted;
	logic       ge;
	logic [6:0] diff;
	logic [7:0] rd_char;
	logic       we;
	logic [CW-1:0] new_len;

	assign shifted = {rem_q, quot_q[VALUE_BITS-1]};
	assign ge      = shifted >= {1'b0, base_q};
	assign diff    = shifted - {1'b0, base_q};
	assign we      = cmd.store;
	assign new_len = (width_q != '0) ? width_q : count_q;

	ritoa_ram #(
		.WIDTH(8),
		.DEPTH(MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(count_q)),
		.wdata(digit_char(rem_q)),
		.re   (cmd.rd),
		.raddr(pos_q),
		.rdata(rd_char)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q  <= num_word.number_value;
			rem_q   <= '0;
			bit_q   <= '0;
			count_q <= '0;
			if (num_word.radix < RADIX_MIN) begin
				base_q <= RADIX_MIN;
			end else if (num_word.radix > RADIX_MAX) begin
				base_q <= RADIX_MAX;
			end else begin
				base_q <= num_word.radix;
			end
			if (int'(num_word.fixed_width) > MAX_DIGITS) begin
				width_q <= CW'(MAX_DIGITS);
			end else begin
				width_q <= CW'(num_word.fixed_width);
			end
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_BITS-2:0], ge};
			rem_q  <= ge ? diff[5:0] : shifted[5:0];
			bit_q  <= bit_q + 1'b1;
		end else if (cmd.store) begin
			rem_q   <= '0;
			bit_q   <= '0;
			count_q <= count_q + 1'b1;
		end
		if (cmd.set_len) begin
			len_q <= new_len;
			pos_q <= AW'(new_len - 1'b1);
		end else if (cmd.emit && pos_q != '0) begin
			pos_q <= pos_q - 1'b1;
		end
		if (cmd.emit) begin
			txt_q.char_code   <= (CW'(pos_q) < count_q) ? rd_char : CHAR_ZERO;
			txt_q.last_char   <= (pos_q == '0);
			txt_q.text_length <= 6'(len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			txt_valid_q <= 1'b1;
		end else if (!txt_stall) begin
			txt_valid_q <= 1'b0;
		end
	end

	assign sts.div_last   = (bit_q == BW'(VALUE_BITS - 1));
	assign sts.q_zero     = (quot_q == '0);
	assign sts.store_full = (count_q == CW'(MAX_DIGITS - 1));
	assign sts.pos_zero   = (pos_q == '0);
	assign sts.out_free   = !txt_valid_q || !txt_stall;

	assign txt_valid = txt_valid_q;
	assign txt_word  = txt_q;

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> int'(count_q) < MAX_DIGITS)
		else $error("digit store written past its depth");

endmodule

[rtl/ritoa_ctrl.sv]
module ritoa_ctrl import ritoa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       num_valid,
	output logic       num_stall,
	input  ritoa_sts_t sts,
	output ritoa_cmd_t cmd
);

	ritoa_state_t state_q;
	ritoa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (num_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = (sts.q_zero || sts.store_full) ? ST_LEN : ST_DIV;
			end
			ST_LEN: begin
				state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) state_d = sts.pos_zero ? ST_IDLE : ST_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		num_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				num_stall = 1'b0;
				cmd.load  = num_valid;
			end
			ST_DIV:   cmd.div_step = 1'b1;
			ST_STORE: cmd.store    = 1'b1;
			ST_LEN:   cmd.set_len  = 1'b1;
			ST_RD:    cmd.rd       = 1'b1;
			ST_LOAD:  cmd.emit     = sts.out_free;
			default: begin
				cmd       = '0;
				num_stall = 1'b1;
			end
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("word loaded over an untaken word");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> state_q == ST_STORE)
		else $error("division did not end in a store");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.pos_zero) |=> (state_q == ST_IDLE && !num_stall))
		else $error("not idle after final character");

endmodule

[rtl/radix_integer_to_ascii.sv]
// Steps: a load, then per natural digit a division through a shared restoring divider
// (one quotient bit per cycle) followed by the digit write, then a step to fix the
// length, then per character a registered store read and a load into the output register.
// One number at a time: a new number is not taken until its last character is loaded.
// The next number is taken while the final character still waits in the output register.
// Reset (arst_n low, asynchronous) returns to idle with no output word pending.
module radix_integer_to_ascii import ritoa_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       num_valid,
	output logic       num_stall,
	input  ritoa_in_t  num_word,
	output logic       txt_valid,
	input  logic       txt_stall,
	output ritoa_out_t txt_word
);

	ritoa_cmd_t cmd;
	ritoa_sts_t sts;

	ritoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_stall(num_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ritoa_datapath #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_word (num_word),
		.cmd      (cmd),
		.sts      (sts),
		.txt_valid(txt_valid),
		.txt_stall(txt_stall),
		.txt_word (txt_word)
	);

endmodule

[sim/tb_radix_integer_to_ascii.sv]
module tb_radix_integer_to_ascii;
	import ritoa_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       num_valid = 1'b0;
	logic       num_stall;
	ritoa_in_t  num_word = '0;
	logic       txt_valid;
	logic       txt_stall = 1'b0;
	ritoa_out_t txt_word;

	ritoa_in_t  pending_numbers[$];
	ritoa_out_t expected_chars[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;

	radix_integer_to_ascii u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num_word  (num_word),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt_word  (txt_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// digits are gathered least significant first, then emitted from the top
	function automatic void predict_text(input ritoa_in_t w);
		logic [7:0]            digits [MAX_DIGITS_DEF];
		logic [VALUE_BITS-1:0] q;
		int unsigned           base, width, ndig, len, pos, d;
		ritoa_out_t            c;
		base = w.radix;
		if (base < 2) base = 2;
		if (base > 36) base = 36;
		width = w.fixed_width;
		if (width > MAX_DIGITS_DEF) width = MAX_DIGITS_DEF;
		q = w.number_value;
		ndig = 0;
		do begin
			d = q % base;
			q = q / base;
			digits[ndig] = (d >= 10 && d <= 22) ? CHAR_ALPHA + 8'(d - 10) : CHAR_ZERO + 8'(d);
			ndig++;
		end while (q != 0 && ndig < MAX_DIGITS_DEF);
		len = (width != 0) ? width : ndig;
		for (int unsigned k = 0; k < len; k++) begin
			pos = len - 1 - k;
			c.char_code   = (pos < ndig) ? digits[pos] : CHAR_ZERO;
			c.last_char   = (k == len - 1);
			c.text_length = 6'(len);
			expected_chars.push_back(c);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (num_valid && !num_stall) begin
				predict_text(num_word);
			end
			if (!num_valid || !num_stall) begin
				if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					num_word  <= pending_numbers.pop_front();
					num_valid <= 1'b1;
				end else begin
					num_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		txt_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		ritoa_out_t e;
		if (arst_n && txt_valid && !txt_stall) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", txt_word));
			end else begin
				e = expected_chars.pop_front();
				if (txt_word.char_code !== e.char_code)
					report_mismatch($sformatf("char_code %h, want %h",
						txt_word.char_code, e.char_code));
				if (txt_word.last_char !== e.last_char)
					report_mismatch($sformatf("last_char %b, want %b",
						txt_word.last_char, e.last_char));
				if (txt_word.text_length !== e.text_length)
					report_mismatch($sformatf("text_length %0d, want %0d",
						txt_word.text_length, e.text_length));
			end
		end
	end

	task automatic queue_number(input logic [31:0] v, input logic [5:0] r,
			input logic [5:0] fw);
		ritoa_in_t w;
		w.number_value = v;
		w.radix        = r;
		w.fixed_width  = fw;
		pending_numbers.push_back(w);
	endtask

	task automatic drain_text();
		while (pending_numbers.size() != 0 || num_valid || expected_chars.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned send_pcts [4] = '{0, 72, 0, 13};
		int unsigned recv_pcts [4] = '{0, 0, 72, 13};
		logic [31:0] v;
		logic [5:0]  r, fw;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		queue_number(32'd0, 6'd10, 6'd0);
		queue_number(32'hFFFF_FFFF, 6'd2, 6'd0);
		queue_number(32'hFFFF_FFFF, 6'd36, 6'd0);
		queue_number(32'hFFFF_FFFF, 6'd16, 6'd0);
		queue_number(32'hFFFF_FFFF, 6'd10, 6'd0);
		queue_number(32'd5, 6'd0, 6'd0);          // base below two
		queue_number(32'd6, 6'd1, 6'd0);
		queue_number(32'd71, 6'd37, 6'd0);        // base above thirty-six
		queue_number(32'hDEAD_BEEF, 6'd63, 6'd0);
		queue_number(32'd10, 6'd11, 6'd0);        // 'A'
		queue_number(32'd22, 6'd23, 6'd0);        // 'M'
		queue_number(32'd23, 6'd36, 6'd0);        // 'G'
		queue_number(32'd35, 6'd36, 6'd0);        // 'S'
		queue_number(32'd12345, 6'd10, 6'd2);     // truncated
		queue_number(32'd5, 6'd10, 6'd8);         // padded
		queue_number(32'd0, 6'd7, 6'd5);
		queue_number(32'h8000_0000, 6'd2, 6'd1);
		queue_number(32'h1234_5678, 6'd16, 6'd32);
		queue_number(32'h0000_00FF, 6'd2, 6'd63); // width saturates
		queue_number(32'hAAAA_AAAA, 6'd35, 6'd33);
		queue_number(32'h5555_5555, 6'd3, 6'd0);
		queue_number(32'h8000_0001, 6'd2, 6'd0);
		queue_number(32'hFFFF_FFFF, 6'd2, 6'd31);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (int i = 0; i < 80; i++) begin
				case ($urandom_range(3))
					0: v = $urandom;
					1: v = $urandom_range(999);
					2: v = $urandom >> $urandom_range(31);
					default: v = {1'($urandom_range(1)), 31'd0} | $urandom_range(35);
				endcase
				r = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
					: 6'($urandom_range(36, 2));
				case ($urandom_range(5))
					0, 1, 2: fw = 6'd0;
					3, 4:    fw = 6'($urandom_range(32, 1));
					default: fw = 6'($urandom_range(63));
				endcase
				queue_number(v, r, fw);
			end
			drain_text();
		end

		repeat (1200) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("radix_integer_to_ascii: match");
		end else begin
			$display("radix_integer_to_ascii: mismatch");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("radix_integer_to_ascii: mismatch");
		$finish;
	end

endmodule
